>>> src/lda_pkg.sv
package lda_pkg;

    localparam int LDA_ADDRESS_BITS = 16;
    localparam int WORD_BITS        = 16;

    localparam logic [7:0] OPC_LDA_IMM  = 8'hA9;
    localparam logic [7:0] OPC_LDA_ZP   = 8'hA5;
    localparam logic [7:0] OPC_LDA_ZPX  = 8'hB5;
    localparam logic [7:0] OPC_LDA_ABS  = 8'hAD;
    localparam logic [7:0] OPC_LDA_ABSX = 8'hBD;
    localparam logic [7:0] OPC_LDA_ABSY = 8'hB9;
    localparam logic [7:0] OPC_LDA_INDX = 8'hA1;
    localparam logic [7:0] OPC_LDA_INDY = 8'hB1;

    localparam logic [7:0] SIGN_MASK = 8'b1000_0000;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_LOAD  = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [7:0]           opcode;
        logic [WORD_BITS-1:0] pc;
        logic [7:0]           index_x;
        logic [7:0]           index_y;
        logic [WORD_BITS-1:0] write_address;
        logic [7:0]           write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]           accumulator;
        logic                 zero_flag;
        logic                 negative_flag;
        logic [WORD_BITS-1:0] next_pc;
        logic [2:0]           cycles_added;
        logic                 recognized;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_IMM,
        OP_ZP,
        OP_ZPX,
        OP_ABS,
        OP_ABSX,
        OP_ABSY,
        OP_INDX,
        OP_INDY
    } op_kind_t;

    typedef enum logic [2:0] {
        ADDR_PC,
        ADDR_ZP,
        ADDR_ZPX,
        ADDR_ZP_NEXT,
        ADDR_ABS
    } addr_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP1,
        S_OP2,
        S_ABS,
        S_ZP,
        S_PHI,
        S_IND,
        S_FIN
    } state_t;

    typedef struct packed {
        logic      capture;
        logic      mem_wr;
        logic      mem_rd;
        addr_sel_t addr_sel;
        logic      pc_inc;
        logic      save_lo;
        logic      save_zp;
        logic      finish;
    } ctrl_cmd_t;

    typedef struct packed {
        op_kind_t kind;
    } dp_status_t;

    function automatic op_kind_t decode_op(input logic [7:0] opcode);
        op_kind_t k;
        case (opcode)
            OPC_LDA_IMM:  k = OP_IMM;
            OPC_LDA_ZP:   k = OP_ZP;
            OPC_LDA_ZPX:  k = OP_ZPX;
            OPC_LDA_ABS:  k = OP_ABS;
            OPC_LDA_ABSX: k = OP_ABSX;
            OPC_LDA_ABSY: k = OP_ABSY;
            OPC_LDA_INDX: k = OP_INDX;
            OPC_LDA_INDY: k = OP_INDY;
            default:      k = OP_NONE;
        endcase
        return k;
    endfunction

    // Bus cycles without the page-cross penalty.
    function automatic logic [2:0] base_cycles(input op_kind_t kind);
        logic [2:0] c;
        case (kind)
            OP_IMM:  c = 3'd1;
            OP_ZP:   c = 3'd2;
            OP_ZPX:  c = 3'd3;
            OP_ABS:  c = 3'd3;
            OP_ABSX: c = 3'd3;
            OP_ABSY: c = 3'd3;
            OP_INDX: c = 3'd5;
            OP_INDY: c = 3'd4;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

>>> src/lda_if.sv
interface lda_in_if;
    logic               valid;
    logic               ready;
    lda_pkg::in_item_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface lda_out_if;
    logic               valid;
    logic               ready;
    lda_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

>>> src/lda_ctrl.sv
module lda_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_mode,
    output logic                   req_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  lda_pkg::dp_status_t    status,
    output lda_pkg::ctrl_cmd_t     cmd
);
    import lda_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        req_ready      = (state_reg == S_IDLE);
        cmd            = '0;
        cmd.addr_sel   = ADDR_PC;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_mode == MODE_LOAD)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_OP1;
                    end
                    else
                    begin
                        cmd.mem_wr = 1'b1;
                    end
                end
            end
            S_OP1:
            begin
                if (status.kind == OP_NONE)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.pc_inc = 1'b1;
                    case (status.kind)
                        OP_IMM:                    state_next = S_FIN;
                        OP_ABS, OP_ABSX, OP_ABSY:  state_next = S_OP2;
                        default:                   state_next = S_ZP;
                    endcase
                end
            end
            S_OP2:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.pc_inc  = 1'b1;
                cmd.save_lo = 1'b1;
                state_next  = S_ABS;
            end
            S_ABS:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_ABS;
                state_next   = S_FIN;
            end
            S_ZP:
            begin
                cmd.mem_rd = 1'b1;
                case (status.kind)
                    OP_ZP:
                    begin
                        cmd.addr_sel = ADDR_ZP;
                        state_next   = S_FIN;
                    end
                    OP_ZPX:
                    begin
                        cmd.addr_sel = ADDR_ZPX;
                        state_next   = S_FIN;
                    end
                    OP_INDX:
                    begin
                        cmd.addr_sel = ADDR_ZPX;
                        cmd.save_zp  = 1'b1;
                        state_next   = S_PHI;
                    end
                    OP_INDY:
                    begin
                        cmd.addr_sel = ADDR_ZP;
                        cmd.save_zp  = 1'b1;
                        state_next   = S_PHI;
                    end
                    default:
                    begin
                        cmd.mem_rd = 1'b0;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_PHI:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_ZP_NEXT;
                cmd.save_lo  = 1'b1;
                state_next   = S_IND;
            end
            S_IND:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_ABS;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                // The read data register holds its value while the result slot is full.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> src/lda_datapath.sv
module lda_datapath #(
    parameter int ADDRESS_BITS = lda_pkg::LDA_ADDRESS_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lda_pkg::in_item_t   item,
    input  lda_pkg::ctrl_cmd_t  cmd,
    output lda_pkg::dp_status_t status,
    output lda_pkg::out_item_t  result
);
    import lda_pkg::*;

    localparam int MEM_DEPTH = 2 ** ADDRESS_BITS;

    logic [7:0]           mem [MEM_DEPTH];
    logic [7:0]           rdata_reg;

    logic [7:0]           op_reg;
    logic [WORD_BITS-1:0] pc_reg;
    logic [7:0]           x_reg;
    logic [7:0]           y_reg;
    logic [7:0]           lo_reg;
    logic [7:0]           zp_reg;
    logic                 pen_reg;
    logic [7:0]           acc_reg;
    logic                 zero_reg;
    logic                 neg_reg;
    out_item_t            out_reg;

    op_kind_t             kind;
    logic [7:0]           idx;
    logic [8:0]           lo_sum;
    logic [WORD_BITS-1:0] mem_addr;
    logic                 known;

    assign kind  = decode_op(op_reg);
    assign known = (kind != OP_NONE);

    always_comb
    begin
        case (kind)
            OP_ABSX: idx = x_reg;
            OP_ABSY: idx = y_reg;
            OP_INDY: idx = y_reg;
            default: idx = 8'h00;
        endcase
    end

    assign lo_sum = {1'b0, lo_reg} + {1'b0, idx};

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_PC:      mem_addr = pc_reg;
            ADDR_ZP:      mem_addr = {8'h00, rdata_reg};
            ADDR_ZPX:     mem_addr = {8'h00, rdata_reg + x_reg};
            ADDR_ZP_NEXT: mem_addr = {8'h00, zp_reg + 8'd1};
            ADDR_ABS:     mem_addr = {rdata_reg, lo_reg} + {8'h00, idx};
            default:      mem_addr = pc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[item.write_address[ADDRESS_BITS-1:0]] <= item.write_data;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[mem_addr[ADDRESS_BITS-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= item.opcode;
            pc_reg <= item.pc;
            x_reg  <= item.index_x;
            y_reg  <= item.index_y;
        end
        else if (cmd.pc_inc)
        begin
            pc_reg <= pc_reg + WORD_BITS'(1);
        end
        if (cmd.save_lo)
        begin
            lo_reg <= rdata_reg;
        end
        if (cmd.save_zp)
        begin
            zp_reg <= mem_addr[7:0];
        end
        if (cmd.capture)
        begin
            pen_reg <= 1'b0;
        end
        else if (cmd.mem_rd && cmd.addr_sel == ADDR_ABS)
        begin
            pen_reg <= lo_sum[8];
        end
        if (cmd.finish)
        begin
            out_reg.accumulator   <= known ? rdata_reg : acc_reg;
            out_reg.zero_flag     <= known ? (rdata_reg == 8'h00) : zero_reg;
            out_reg.negative_flag <= known ? |(rdata_reg & SIGN_MASK) : neg_reg;
            out_reg.next_pc       <= pc_reg;
            out_reg.cycles_added  <= base_cycles(kind) + {2'b00, pen_reg};
            out_reg.recognized    <= known;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 8'h00;
            zero_reg <= 1'b0;
            neg_reg  <= 1'b0;
        end
        else if (cmd.finish && known)
        begin
            acc_reg  <= rdata_reg;
            zero_reg <= (rdata_reg == 8'h00);
            neg_reg  <= |(rdata_reg & SIGN_MASK);
        end
    end

    assign status.kind = kind;
    assign result      = out_reg;

endmodule

>>> src/load_accumulator_addressing_unit_core.sv
// Load-accumulator unit with its own 64 KiB byte memory.
// request carries two kinds of item. A write item (mode 0) stores write_data at
// write_address in the cycle it is accepted and gives no result; the next item
// may follow in the next cycle. A load item (mode 1) runs the opcode against the
// memory and gives exactly one item on result.
// A load passes through one state per memory read plus a finish state, since
// the memory has a single port with registered read data. Immediate reads the
// operand; zero page and zero page,X read the address, then the data; absolute
// modes read two address bytes, then the data; both indirect modes read the zero
// page address, both pointer bytes, then the data; an unknown opcode reads none.
// request.ready is high again in the cycle the result appears and low while a load runs.
// The result sits in an output register; a stalled receiver does not stop the
// unit taking the next item, and a load that finishes while the previous result
// is still waiting holds until that result is taken.
// Reset clears the accumulator, the flags and the handshake state; memory
// contents are undefined until written, and no clearing pass is run.
module load_accumulator_addressing_unit_core #(
    parameter int ADDRESS_BITS = lda_pkg::LDA_ADDRESS_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    lda_in_if.sink    request,
    lda_out_if.source result
);
    import lda_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    lda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_mode  (request.item.mode),
        .req_ready (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lda_datapath #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (request.item),
        .cmd    (cmd),
        .status (status),
        .result (result.item)
    );

endmodule

>>> src/lda_checker.sv
module lda_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input lda_pkg::in_item_t  req_item,
    input logic               res_valid,
    input logic               res_ready,
    input lda_pkg::out_item_t res_item
);
    import lda_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result item changed while stalled");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_item.mode == MODE_LOAD |=> !req_ready)
        else $error("new item taken while a load is in progress");

    a_unknown_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.recognized |-> res_item.cycles_added == 3'd0)
        else $error("unrecognised opcode reported bus cycles");

    a_known_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.recognized
        |-> res_item.cycles_added != 3'd0 && res_item.cycles_added <= 3'd5)
        else $error("cycle count out of range");

    // The reset flags do not follow the reset accumulator, so only loads are checked.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.recognized
        |-> res_item.zero_flag == (res_item.accumulator == 8'h00)
            && res_item.negative_flag == res_item.accumulator[7])
        else $error("flags disagree with accumulator");

endmodule

bind load_accumulator_addressing_unit_core lda_checker u_lda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .req_item  (request.item),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_item  (result.item)
);
